@@ rtl/ubrf_pkg.sv @@
// shared types and constants for the buffered uart ring front end
package ubrf_pkg;

    localparam int RX_DEPTH  = 16;
    localparam int TX_DEPTH  = 16;
    localparam int RX_PTR_W  = $clog2(2 * RX_DEPTH);
    localparam int RX_SLOT_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W  = $clog2(2 * TX_DEPTH);
    localparam int TX_SLOT_W = $clog2(TX_DEPTH);

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        OP_LINE_BYTE  = 2'd0,
        OP_TX_DONE    = 2'd1,
        OP_HOST_READ  = 2'd2,
        OP_HOST_WRITE = 2'd3
    } t_op;

    typedef struct packed {
        t_op        operation;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic       accepted;
        logic       tx_start;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
        logic       rx_empty;
        logic       tx_empty;
        logic       tx_full;
        logic       tx_busy;
    } t_result;

    // receive ring control from the top level
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wr_byte;
    } t_rx_ctl;

    // receive ring status back to the top level
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] rd_byte;
    } t_rx_stat;

endpackage

@@ rtl/ubrf_rx_ring.sv @@
// receive ring: byte store, read and write pointers, fill status
module ubrf_rx_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ubrf_pkg::t_rx_ctl  i_ctl,
    output ubrf_pkg::t_rx_stat o_stat,
    output logic               o_empty_next
);

    localparam int PW = ubrf_pkg::RX_PTR_W;
    localparam int SW = ubrf_pkg::RX_SLOT_W;
    localparam int LW = PW + 1;
    localparam logic [PW-1:0] PTR_D    = PW'(ubrf_pkg::RX_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * ubrf_pkg::RX_DEPTH - 1);
    localparam logic [LW-1:0] LVL_D    = LW'(ubrf_pkg::RX_DEPTH);
    localparam logic [LW-1:0] LVL_2D   = LW'(2 * ubrf_pkg::RX_DEPTH);

    logic [PW-1:0] r_rd;
    logic [PW-1:0] r_wr;
    logic [PW-1:0] n_rd;
    logic [PW-1:0] n_wr;
    logic [7:0]    r_store [ubrf_pkg::RX_DEPTH];

    logic [PW-1:0] w_rd_off;
    logic [PW-1:0] w_wr_off;
    logic [SW-1:0] w_rd_slot;
    logic [SW-1:0] w_wr_slot;
    logic [LW-1:0] w_level;

    always_comb begin
        w_rd_off  = (r_rd >= PTR_D) ? r_rd - PTR_D : r_rd;
        w_wr_off  = (r_wr >= PTR_D) ? r_wr - PTR_D : r_wr;
        w_rd_slot = w_rd_off[SW-1:0];
        w_wr_slot = w_wr_off[SW-1:0];
        if (r_wr >= r_rd) begin
            w_level = {1'b0, r_wr} - {1'b0, r_rd};
        end else begin
            w_level = {1'b0, r_wr} + LVL_2D - {1'b0, r_rd};
        end
    end

    always_comb begin
        n_rd = r_rd;
        n_wr = r_wr;
        if (i_ctl.push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_ctl.pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
    end

    assign o_stat.empty   = (r_rd == r_wr);
    assign o_stat.full    = (w_level >= LVL_D);
    assign o_stat.rd_byte = r_store[w_rd_slot];
    assign o_empty_next   = (n_rd == n_wr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            r_rd <= n_rd;
            r_wr <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_store[w_wr_slot] <= i_ctl.wr_byte;
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LVL_D)
        else $error("rx ring level beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_stat.full)
        else $error("rx push into full ring");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_stat.empty && !i_ctl.push)
        else $error("rx pop from empty ring or together with push");

endmodule

@@ rtl/uart_buffered_ring_fifos_unit.sv @@
// buffered uart front end: receive ring, transmit ring and transmitter handoff
// An item (line byte, transmitter done, host read or host write) is taken on any
// cycle with start high; busy never rises, so one item per clock is sustained.
// Each item yields one result on o_result, marked by o_valid once the item has
// passed the input register and then the result register; results cannot
// be held off and must be captured in the cycle o_valid is high. Ring pointers
// update in the same pass, so back-to-back items see each other's effects.
// Both rings hold 16 bytes; a line feed from the host is sent as CR then LF.
module uart_buffered_ring_fifos_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ubrf_pkg::t_item   i_item,
    output logic              o_valid,
    output ubrf_pkg::t_result o_result
);

    localparam int PW = ubrf_pkg::TX_PTR_W;
    localparam int SW = ubrf_pkg::TX_SLOT_W;
    localparam int LW = PW + 1;
    localparam logic [PW-1:0] PTR_D    = PW'(ubrf_pkg::TX_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * ubrf_pkg::TX_DEPTH - 1);
    localparam logic [LW-1:0] LVL_D    = LW'(ubrf_pkg::TX_DEPTH);
    localparam logic [LW-1:0] LVL_2D   = LW'(2 * ubrf_pkg::TX_DEPTH);

    logic              r_in_valid;
    ubrf_pkg::t_item   r_in;
    logic              r_out_valid;
    ubrf_pkg::t_result r_out;

    logic [PW-1:0]     r_tx_rd;
    logic [PW-1:0]     r_tx_wr;
    logic              r_send_busy;
    logic              r_send_full;
    logic [PW-1:0]     n_tx_rd;
    logic [PW-1:0]     n_tx_wr;
    logic              n_send_busy;
    logic              n_send_full;
    logic [7:0]        r_tx_store [ubrf_pkg::TX_DEPTH];

    ubrf_pkg::t_rx_ctl  w_rx_ctl;
    ubrf_pkg::t_rx_stat w_rx_stat;
    logic               w_rx_empty_next;

    logic [PW-1:0] w_rd_off;
    logic [PW-1:0] w_wr_off;
    logic [PW-1:0] w_nx_off;
    logic [SW-1:0] w_rd_slot;
    logic [SW-1:0] w_wr_slot;
    logic [SW-1:0] w_nx_slot;
    logic [PW-1:0] w_wr_next;
    logic [PW-1:0] w_wr_next2;
    logic [PW-1:0] w_rd_next;
    logic [LW-1:0] w_level;
    logic [LW-1:0] w_room;
    logic [LW-1:0] w_need;
    logic [LW-1:0] w_level_after;
    logic          w_is_lf;
    logic          w_tx_empty;

    logic          w_we_a;
    logic          w_we_b;
    logic [7:0]    w_byte_a;
    ubrf_pkg::t_result w_res;

    ubrf_rx_ring u_rx_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_rx_ctl),
        .o_stat       (w_rx_stat),
        .o_empty_next (w_rx_empty_next)
    );

    // transmit ring addressing
    always_comb begin
        w_wr_next  = (r_tx_wr == PTR_LAST) ? '0 : r_tx_wr + 1'b1;
        w_wr_next2 = (w_wr_next == PTR_LAST) ? '0 : w_wr_next + 1'b1;
        w_rd_next  = (r_tx_rd == PTR_LAST) ? '0 : r_tx_rd + 1'b1;
        w_rd_off   = (r_tx_rd >= PTR_D) ? r_tx_rd - PTR_D : r_tx_rd;
        w_wr_off   = (r_tx_wr >= PTR_D) ? r_tx_wr - PTR_D : r_tx_wr;
        w_nx_off   = (w_wr_next >= PTR_D) ? w_wr_next - PTR_D : w_wr_next;
        w_rd_slot  = w_rd_off[SW-1:0];
        w_wr_slot  = w_wr_off[SW-1:0];
        w_nx_slot  = w_nx_off[SW-1:0];
        if (r_tx_wr >= r_tx_rd) begin
            w_level = {1'b0, r_tx_wr} - {1'b0, r_tx_rd};
        end else begin
            w_level = {1'b0, r_tx_wr} + LVL_2D - {1'b0, r_tx_rd};
        end
        w_room     = (w_level <= LVL_D) ? LVL_D - w_level : '0;
        w_is_lf    = (r_in.data_byte == ubrf_pkg::LF_BYTE);
        w_need     = LW'({r_send_busy & w_is_lf, r_send_busy ^ w_is_lf});
        w_tx_empty = (r_tx_rd == r_tx_wr);
    end

    always_comb begin
        n_tx_rd       = r_tx_rd;
        n_tx_wr       = r_tx_wr;
        n_send_busy   = r_send_busy;
        n_send_full   = r_send_full;
        w_rx_ctl      = '0;
        w_rx_ctl.wr_byte = r_in.data_byte;
        w_we_a        = 1'b0;
        w_we_b        = 1'b0;
        w_byte_a      = r_in.data_byte;
        w_level_after = w_level;
        w_res         = '0;

        if (r_in_valid) begin
            case (r_in.operation)
                ubrf_pkg::OP_LINE_BYTE: begin
                    if (!w_rx_stat.full) begin
                        w_rx_ctl.push = 1'b1;
                        w_res.accepted = 1'b1;
                    end
                end
                ubrf_pkg::OP_TX_DONE: begin
                    if (r_send_busy) begin
                        w_res.accepted = 1'b1;
                        if (!w_tx_empty) begin
                            w_res.tx_start = 1'b1;
                            w_res.tx_byte  = r_tx_store[w_rd_slot];
                            n_tx_rd        = w_rd_next;
                            n_send_full    = 1'b0;
                        end else begin
                            n_send_busy = 1'b0;
                        end
                    end
                end
                ubrf_pkg::OP_HOST_READ: begin
                    if (!w_rx_stat.empty) begin
                        w_rx_ctl.pop   = 1'b1;
                        w_res.accepted = 1'b1;
                        w_res.rx_byte  = w_rx_stat.rd_byte;
                    end
                end
                default: begin
                    if (w_room >= w_need) begin
                        w_res.accepted = 1'b1;
                        if (!r_send_busy) begin
                            // idle transmitter takes the byte (or the cr) at once
                            n_send_busy    = 1'b1;
                            w_res.tx_start = 1'b1;
                            w_res.tx_byte  = w_is_lf ? ubrf_pkg::CR_BYTE : r_in.data_byte;
                            if (w_is_lf) begin
                                w_we_a  = 1'b1;
                                n_tx_wr = w_wr_next;
                            end
                        end else begin
                            w_we_a   = 1'b1;
                            w_byte_a = w_is_lf ? ubrf_pkg::CR_BYTE : r_in.data_byte;
                            w_we_b   = w_is_lf;
                            n_tx_wr  = w_is_lf ? w_wr_next2 : w_wr_next;
                        end
                        if (w_we_a) begin
                            w_level_after = w_level + LW'({w_we_b, ~w_we_b});
                            n_send_full   = (w_level_after >= LVL_D);
                        end
                    end
                end
            endcase
        end

        w_res.rx_empty = w_rx_empty_next;
        w_res.tx_empty = (n_tx_rd == n_tx_wr);
        w_res.tx_full  = n_send_full;
        w_res.tx_busy  = n_send_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tx_rd     <= '0;
            r_tx_wr     <= '0;
            r_send_busy <= 1'b0;
            r_send_full <= 1'b0;
        end else begin
            r_in_valid  <= start;
            r_out_valid <= r_in_valid;
            r_tx_rd     <= n_tx_rd;
            r_tx_wr     <= n_tx_wr;
            r_send_busy <= n_send_busy;
            r_send_full <= n_send_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_out <= w_res;
        end
        if (w_we_a) begin
            r_tx_store[w_wr_slot] <= w_byte_a;
        end
        if (w_we_b) begin
            r_tx_store[w_nx_slot] <= r_in.data_byte;
        end
    end

    assign busy     = 1'b0;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result without an accepted item");

    a_idle_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_send_busy |-> (r_tx_rd == r_tx_wr))
        else $error("transmitter idle with bytes queued");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_send_full |-> (r_tx_rd != r_tx_wr) && r_send_busy)
        else $error("tx full flag with empty ring or idle transmitter");

    a_start_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.tx_start |-> o_result.tx_busy && o_result.accepted)
        else $error("byte started without busy transmitter");

endmodule
